[hw/rtl/assert_macros.svh]
// Assertion helpers for the graph bridge counter RTL.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GBC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define GBC_ASSERT(lbl, prop, msg)
`define GBC_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared sizes and state encoding for the graph bridge counter.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 128;

    // Fixed field width of vertex numbers and the vertex count register.
    localparam int VTX_W   = 7;
    // Index of a vertex inside the walk (0-based).
    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    // Counts that can reach MAX_VERTICES (stack pointer, components).
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    // Edge store address and edge count.
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    // One stored edge holds both endpoints.
    localparam int EDGE_W  = 2 * VTX_W;
    localparam int BRIDGE_W = 8;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_INIT = 7'b0000010,
        ST_ROOT = 7'b0000100,
        ST_POP  = 7'b0001000,
        ST_POPW = 7'b0010000,
        ST_SCAN = 7'b0100000,
        ST_PASS = 7'b1000000
    } t_state;

endpackage

[hw/rtl/gbc_ram.sv]
// ----------------------------------------------------------------------------
// gbc_ram
// Simple dual-port RAM: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module gbc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/graph_bridge_counter.sv]
// Edge transactions are taken only while loading. A last transaction starts E+1
// component passes over E stored edges; each pass goes through the single read port
// of the edge store, which is scanned once per popped vertex. The result then waits
// for a free output register.
// Throughput: one edge per cycle while loading, input stalled during passes.
// Reset: synchronous active low; clears control and edge count, vertex count=1.
// ----------------------------------------------------------------------------
// graph_bridge_counter
// Loads a multigraph edge by edge and counts its bridges by removing each
// edge in turn and recounting connected components with a stack-based walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module graph_bridge_counter
    import gbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [VTX_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [VTX_W-1:0]    i_end_a,
    input  logic [VTX_W-1:0]    i_end_b,
    input  logic                i_edge_valid,
    input  logic                i_last_edge,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [BRIDGE_W-1:0] o_bridge_count,
    output logic                o_overflow
);

    t_state r_state, n_state;

    logic [VTX_W-1:0]        r_vcount;
    logic [ECNT_W-1:0]       r_edge_total, n_edge_total;
    logic                    r_ovf, n_ovf;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VCNT_W-1:0]       r_sp, n_sp;
    logic [VCNT_W-1:0]       r_root, n_root;
    logic [VCNT_W-1:0]       r_comps, n_comps;
    logic [VCNT_W-1:0]       r_base, n_base;
    logic [ECNT_W-1:0]       r_pass, n_pass;
    logic [EADDR_W-1:0]      r_ep, n_ep;
    logic [VIDX_W-1:0]       r_u, n_u;
    logic [BRIDGE_W-1:0]     r_bridges, n_bridges;
    logic                    r_out_valid, n_out_valid;
    logic [BRIDGE_W-1:0]     r_out_count, n_out_count;
    logic                    r_out_ovf, n_out_ovf;

    logic                    in_acc;
    logic                    e_we;
    logic [EADDR_W-1:0]      e_raddr;
    logic [EDGE_W-1:0]       e_rdata;
    logic                    s_we;
    logic [VIDX_W-1:0]       s_waddr;
    logic [VIDX_W-1:0]       s_wdata;
    logic [VIDX_W-1:0]       s_raddr;
    logic [VIDX_W-1:0]       s_rdata;

    logic [VCNT_W-1:0]       nv;
    logic [VTX_W-1:0]        ea, eb;
    logic                    e_inrange, e_skip, e_hit;
    logic [VIDX_W-1:0]       ea_i, eb_i, other;
    logic [ECNT_W-1:0]       ep_ext;

    // Input side takes transactions only while loading.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign e_we       = in_acc && i_edge_valid && (r_edge_total < ECNT_W'(MAX_EDGES));

    // Effective vertex count, clamped to the walk capacity.
    assign nv = (r_vcount > VTX_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                   : VCNT_W'(r_vcount);

    gbc_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_W)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_edge_total[EADDR_W-1:0]),
        .i_wdata ({i_end_a, i_end_b}),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    gbc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VIDX_W)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Decode of the edge currently on the store's read port.
    assign ea        = e_rdata[EDGE_W-1:VTX_W];
    assign eb        = e_rdata[VTX_W-1:0];
    assign ea_i      = VIDX_W'(ea - VTX_W'(1));
    assign eb_i      = VIDX_W'(eb - VTX_W'(1));
    assign ep_ext    = ECNT_W'(r_ep);
    assign e_skip    = (r_pass != '0) && (ep_ext == r_pass - ECNT_W'(1));
    assign e_inrange = (ea != '0) && (eb != '0) &&
                       (VCNT_W'(ea) <= nv) && (VCNT_W'(eb) <= nv);
    assign e_hit     = !e_skip && e_inrange && ((ea_i == r_u) || (eb_i == r_u));
    assign other     = (ea_i == r_u) ? eb_i : ea_i;

    // Sequencer: loading, then one component walk per pass.
    always_comb begin
        n_state      = r_state;
        n_edge_total = r_edge_total;
        n_ovf        = r_ovf;
        n_visited    = r_visited;
        n_sp         = r_sp;
        n_root       = r_root;
        n_comps      = r_comps;
        n_base       = r_base;
        n_pass       = r_pass;
        n_ep         = r_ep;
        n_u          = r_u;
        n_bridges    = r_bridges;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_count  = r_out_count;
        n_out_ovf    = r_out_ovf;
        e_raddr      = r_ep + EADDR_W'(1);
        s_we         = 1'b0;
        s_waddr      = r_sp[VIDX_W-1:0];
        s_wdata      = '0;
        s_raddr      = VIDX_W'(r_sp - VCNT_W'(1));

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (e_we) begin
                        n_edge_total = r_edge_total + ECNT_W'(1);
                    end else if (i_edge_valid) begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_edge) begin
                        n_pass    = '0;
                        n_bridges = '0;
                        n_state   = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                n_visited = '0;
                n_comps   = '0;
                n_root    = '0;
                n_sp      = '0;
                n_state   = ST_ROOT;
            end
            ST_ROOT: begin
                if (r_root >= nv) begin
                    n_state = ST_PASS;
                end else if (r_visited[r_root[VIDX_W-1:0]]) begin
                    n_root = r_root + VCNT_W'(1);
                end else begin
                    // New component: mark the root and push it.
                    n_comps = r_comps + VCNT_W'(1);
                    n_visited[r_root[VIDX_W-1:0]] = 1'b1;
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = r_root[VIDX_W-1:0];
                    n_sp    = VCNT_W'(1);
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (r_sp == '0) begin
                    n_root  = r_root + VCNT_W'(1);
                    n_state = ST_ROOT;
                end else begin
                    n_sp    = r_sp - VCNT_W'(1);
                    n_state = ST_POPW;
                end
            end
            ST_POPW: begin
                // Popped vertex is ready; start reading edges from entry zero.
                n_u     = s_rdata;
                e_raddr = '0;
                n_ep    = '0;
                n_state = (r_edge_total == '0) ? ST_POP : ST_SCAN;
            end
            ST_SCAN: begin
                if (e_hit && !r_visited[other] && (r_sp < VCNT_W'(MAX_VERTICES))) begin
                    n_visited[other] = 1'b1;
                    s_we    = 1'b1;
                    s_wdata = other;
                    n_sp    = r_sp + VCNT_W'(1);
                end
                if (ep_ext + ECNT_W'(1) < r_edge_total) begin
                    n_ep = r_ep + EADDR_W'(1);
                end else begin
                    n_state = ST_POP;
                end
            end
            ST_PASS: begin
                if (r_pass == '0) begin
                    n_base = r_comps;
                end else if ((r_comps > r_base) && (r_bridges != '1)) begin
                    n_bridges = r_bridges + BRIDGE_W'(1);
                end
                if (r_pass == r_edge_total) begin
                    if (!r_out_valid || !i_out_stall) begin
                        // Present the result once the output register is free.
                        n_out_valid  = 1'b1;
                        n_out_count  = n_bridges;
                        n_out_ovf    = r_ovf;
                        n_edge_total = '0;
                        n_ovf        = 1'b0;
                        n_state      = ST_IDLE;
                    end else begin
                        // Output register still full: wait here without counting again.
                        n_bridges = r_bridges;
                    end
                end else begin
                    n_pass  = r_pass + ECNT_W'(1);
                    n_state = ST_INIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vcount     <= VTX_W'(1);
            r_edge_total <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_visited    <= '0;
            r_sp         <= '0;
            r_comps      <= '0;
            r_base       <= '0;
            r_bridges    <= '0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
            r_visited    <= n_visited;
            r_sp         <= n_sp;
            r_comps      <= n_comps;
            r_base       <= n_base;
            r_bridges    <= n_bridges;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    // Walk and result payload registers.
    always_ff @(posedge i_clk) begin
        r_root      <= n_root;
        r_pass      <= n_pass;
        r_ep        <= n_ep;
        r_u         <= n_u;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid    = r_out_valid;
    assign o_bridge_count = r_out_count;
    assign o_overflow     = r_out_ovf;

    // Design checks.
    `GBC_NEVER(a_sp_range, r_sp > VCNT_W'(MAX_VERTICES), "walk stack pointer past capacity")
    `GBC_NEVER(a_total_range, r_edge_total > ECNT_W'(MAX_EDGES), "edge count past store size")
    `GBC_ASSERT(a_scan_bound, (r_state == ST_SCAN) |-> (ep_ext < r_edge_total), "scan past stored edges")
    `GBC_ASSERT(a_done_out, (r_state == ST_PASS && n_state == ST_IDLE) |=> o_out_valid, "result not presented")

endmodule

[tb/graph_bridge_counter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bridge_counter_test
// Self-checking bench for the bridge counter. Graphs are loaded one edge
// transaction at a time. A behavioral bridge predictor computes each expected
// count unless a directed row gives it, and a monitor compares every result with it.
// ----------------------------------------------------------------------------
module graph_bridge_counter_test;
    import gbc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    // One row of the directed stimulus table.
    typedef struct {
        bit             cfg_set;
        logic [VTX_W-1:0] cfg_val;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        bit             ev;
        bit             last;
        bit             typed;
        int             exp_bridges;
        bit             exp_ovf;
    } t_row;

    typedef struct {
        logic [BRIDGE_W-1:0] bridges;
        logic                ovf;
    } t_bridge_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [VTX_W-1:0]    i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [VTX_W-1:0]    i_end_a;
    logic [VTX_W-1:0]    i_end_b;
    logic                i_edge_valid;
    logic                i_last_edge;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [BRIDGE_W-1:0] o_bridge_count;
    logic                o_overflow;

    graph_bridge_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_end_a        (i_end_a),
        .i_end_b        (i_end_b),
        .i_edge_valid   (i_edge_valid),
        .i_last_edge    (i_last_edge),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bridge_count (o_bridge_count),
        .o_overflow     (o_overflow)
    );

    // Predictor state: a mirror of the edge store and the vertex count.
    logic [VTX_W-1:0] pred_a [MAX_EDGES];
    logic [VTX_W-1:0] pred_b [MAX_EDGES];
    int               pred_edges;
    bit               pred_ovf;
    int               pred_vcount;

    t_bridge_result expected_bridges[$];
    t_row           rows[$];

    int  errors = 0;
    int  results_seen = 0;
    int  graphs_sent;
    int  items_sent;
    int  cycles = 0;
    bit  quiet;
    bit  hold_req;

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("graph_bridge_counter_test NOT OK");
            $finish;
        end
    end

    // Appends one row to the directed table.
    function automatic void add_row(input t_row r);
        rows.insert(rows.size(), r);
    endfunction

    // Counts components with a depth-first walk, leaving out at most one edge.
    function automatic int walk_components(int skip, int nv);
        bit seen [MAX_VERTICES];
        int stack [MAX_VERTICES];
        int sp;
        int comps;
        int u;
        int ea;
        int eb;
        int other;
        comps = 0;
        for (int v = 0; v < MAX_VERTICES; v++) seen[v] = 0;
        for (int r = 0; r < nv; r++) begin
            if (!seen[r]) begin
                comps++;
                seen[r] = 1;
                sp = 0;
                stack[sp++] = r;
                while (sp > 0) begin
                    u = stack[--sp];
                    for (int e = 0; e < pred_edges; e++) begin
                        ea = pred_a[e];
                        eb = pred_b[e];
                        if (e == skip || ea < 1 || ea > nv || eb < 1 || eb > nv)
                            continue;
                        ea--;
                        eb--;
                        if (ea == u) other = eb;
                        else if (eb == u) other = ea;
                        else continue;
                        if (!seen[other] && sp < MAX_VERTICES) begin
                            seen[other] = 1;
                            stack[sp++] = other;
                        end
                    end
                end
            end
        end
        return comps;
    endfunction

    // Applies one accepted transaction; returns 1 with a result on a last item.
    function automatic bit predict_bridges(input logic [VTX_W-1:0] a,
                                           input logic [VTX_W-1:0] b,
                                           input bit ev, input bit last,
                                           output t_bridge_result res);
        int nv;
        int base;
        int found;
        if (ev) begin
            if (pred_edges < MAX_EDGES) begin
                pred_a[pred_edges] = a;
                pred_b[pred_edges] = b;
                pred_edges++;
            end else begin
                pred_ovf = 1;
            end
        end
        if (!last) return 0;
        nv = (pred_vcount > MAX_VERTICES) ? MAX_VERTICES : pred_vcount;
        base = walk_components(-1, nv);
        found = 0;
        for (int e = 0; e < pred_edges; e++)
            if (walk_components(e, nv) > base) found++;
        res.bridges = (found > 255) ? 8'd255 : found[BRIDGE_W-1:0];
        res.ovf = pred_ovf;
        pred_edges = 0;
        pred_ovf = 0;
        return 1;
    endfunction

    // Writes the vertex count once all results are in and the block is idle.
    task automatic write_vertex_count(input logic [VTX_W-1:0] val);
        while (expected_bridges.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pred_vcount = val;
    endtask

    // Offers one edge transaction and waits until it is accepted.
    task automatic send_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                             input bit ev, input bit last,
                             input bit typed, input int exp_b, input bit exp_o);
        t_bridge_result res;
        while (!quiet && $urandom_range(99) < 6) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_end_a = a;
        i_end_b = b;
        i_edge_valid = ev;
        i_last_edge = last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (predict_bridges(a, b, ev, last, res)) begin
            graphs_sent++;
            if (typed) begin
                res.bridges = exp_b[BRIDGE_W-1:0];
                res.ovf = exp_o;
            end
            expected_bridges.insert(expected_bridges.size(), res);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Result side stall: random idling plus one long hold-off on request.
    initial begin
        int hold_cycles;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = (!quiet && $urandom_range(99) < 6);
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_bridge_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_bridges.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: bridges=%0d overflow=%0b",
                             o_bridge_count, o_overflow);
            end else begin
                want = expected_bridges.pop_front();
                if (o_bridge_count !== want.bridges || o_overflow !== want.ovf) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: bridges exp %0d got %0d, overflow exp %0b got %0b",
                                 want.bridges, o_bridge_count, want.ovf, o_overflow);
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        int   nedges;
        int   vc;
        int   span;
        logic [VTX_W-1:0] ra;
        logic [VTX_W-1:0] rb;
        int   wait_cycles;

        graphs_sent = 0;
        items_sent = 0;
        quiet = 0;
        hold_req = 0;
        pred_edges = 0;
        pred_ovf = 0;
        pred_vcount = 1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_end_a = '0;
        i_end_b = '0;
        i_edge_valid = 1'b0;
        i_last_edge = 1'b0;

        // Directed table: cfg_set, cfg_val, a, b, ev, last, typed, bridges, overflow.
        // Empty graph right after reset.
        add_row('{0, 0, 0, 0, 0, 1, 1, 0, 0});
        // A single edge is a bridge.
        add_row('{1, 2, 1, 2, 1, 1, 1, 1, 0});
        // A doubled edge is never a bridge.
        add_row('{0, 0, 1, 2, 1, 0, 0, 0, 0});
        add_row('{0, 0, 2, 1, 1, 1, 1, 0, 0});
        // No vertices at all: the edge is skipped.
        add_row('{1, 0, 1, 1, 1, 1, 1, 0, 0});
        // Out-of-range endpoints stay stored but are never walked.
        add_row('{1, 64, 1, 64, 1, 0, 0, 0, 0});
        add_row('{0, 0, 64, 0, 1, 0, 0, 0, 0});
        add_row('{0, 0, 127, 127, 1, 1, 1, 1, 0});
        // Oversized vertex count is clamped; a self-loop is not a bridge.
        add_row('{1, 127, 3, 3, 1, 0, 0, 0, 0});
        add_row('{0, 0, 63, 64, 1, 1, 1, 1, 0});
        // A path with an empty last marker; a cycle closes it later.
        add_row('{1, 3, 1, 2, 1, 0, 0, 0, 0});
        add_row('{0, 0, 2, 3, 1, 0, 0, 0, 0});
        add_row('{0, 0, 127, 0, 0, 1, 1, 2, 0});
        add_row('{0, 0, 1, 2, 1, 0, 0, 0, 0});
        add_row('{0, 0, 2, 3, 1, 0, 0, 0, 0});
        add_row('{0, 0, 3, 1, 1, 0, 0, 0, 0});
        add_row('{0, 0, 3, 4, 1, 1, 0, 0, 0});

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].cfg_set) write_vertex_count(rows[i].cfg_val);
            send_edge(rows[i].a, rows[i].b, rows[i].ev, rows[i].last,
                      rows[i].typed, rows[i].exp_bridges, rows[i].exp_ovf);
        end

        // Overflow: more edges than the store holds, on two vertices.
        write_vertex_count(VTX_W'(2));
        for (int i = 0; i < MAX_EDGES + 2; i++)
            send_edge(VTX_W'(1), VTX_W'(2), 1'b1, (i == MAX_EDGES + 1), 1'b0, 0, 1'b0);
        send_edge(VTX_W'(1), VTX_W'(2), 1'b1, 1'b1, 1'b0, 0, 1'b0);

        // The receiver holds off while small graphs keep coming, so the input stalls.
        hold_req = 1;
        for (int g = 0; g < 3; g++) begin
            send_edge(VTX_W'(1), VTX_W'(2), 1'b1, 1'b0, 1'b0, 0, 1'b0);
            send_edge(VTX_W'(2), VTX_W'(1), 1'b1, 1'b1, 1'b0, 0, 1'b0);
        end

        // Random graphs.
        while (items_sent < 400) begin
            quiet = (items_sent > 200 && items_sent < 300);
            if ($urandom_range(3) == 0 || graphs_sent < 25) begin
                case ($urandom_range(9))
                    0: vc = 0;
                    1: vc = 64;
                    2: vc = $urandom_range(127);
                    default: vc = $urandom_range(12, 1);
                endcase
                write_vertex_count(vc[VTX_W-1:0]);
            end
            vc = (pred_vcount > MAX_VERTICES) ? MAX_VERTICES : pred_vcount;
            span = (vc < 1) ? 1 : vc;
            nedges = $urandom_range(10);
            for (int e = 0; e <= nedges; e++) begin
                if ($urandom_range(19) == 0) begin
                    ra = VTX_W'($urandom);
                    rb = VTX_W'($urandom);
                end else begin
                    ra = VTX_W'($urandom_range(span, 1));
                    rb = VTX_W'($urandom_range(span, 1));
                end
                if (e == nedges)
                    send_edge(ra, rb, ($urandom_range(4) != 0), 1, 0, 0, 0);
                else if ($urandom_range(14) == 0)
                    send_edge(ra, rb, 0, 0, 0, 0, 0);
                else
                    send_edge(ra, rb, 1, 0, 0, 0, 0);
            end
        end
        quiet = 0;

        // Drain: wait for every expected result, then let the block settle.
        wait_cycles = 0;
        while (expected_bridges.size() != 0 && wait_cycles < 2000000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(negedge i_clk);

        $display("Sent %0d edge transactions in %0d graphs, checked %0d results.",
                 items_sent, graphs_sent, results_seen);
        $display("Covered empty graphs, multi-edges, self-loops, clamping and overflow.");
        if (errors == 0 && expected_bridges.size() == 0) begin
            $display("graph_bridge_counter_test OK");
        end else begin
            $display("Failures: %0d mismatches, %0d results missing",
                     errors, expected_bridges.size());
            $display("graph_bridge_counter_test NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/gbc_pkg.sv
hw/rtl/gbc_ram.sv
hw/rtl/graph_bridge_counter.sv
tb/graph_bridge_counter_test.sv
